### hw/rtl/pidwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidwd_pkg: shared types and constants of the PID drive controller
// Register map, configuration bundle and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package pidwd_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int DRIVE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int WF_W    = 17;
  localparam int INTEG_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUT_LOW,
    REG_OUT_HIGH,
    REG_TARGET,
    REG_WINDUP_FACTOR,
    REG_RUN_ENABLE
  } reg_idx_t;

  localparam logic signed [GAIN_W-1:0]  GAIN_RST     = 16'sd0;
  localparam logic signed [DRIVE_W-1:0] OUT_LOW_RST  = 16'sh8000;
  localparam logic signed [DRIVE_W-1:0] OUT_HIGH_RST = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] TARGET_RST   = 16'sd0;
  localparam logic [WF_W-1:0]           WF_RST       = 17'd3277;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [DRIVE_W-1:0] out_low;
    logic signed [DRIVE_W-1:0] out_high;
    logic signed [DRIVE_W-1:0] target;
    logic [WF_W-1:0]           windup_factor;
    logic                      run_enable;
  } cfg_t;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_WF,
    MUL_P,
    MUL_D,
    MUL_I
  } mul_sel_t;

  typedef struct packed {
    logic     take_run;
    logic     take_off;
    mul_sel_t mul_sel;
    logic     integ_en;
    logic     acc_clr;
    logic     acc_add;
    logic     commit_run;
    logic     commit_off;
  } cmd_t;

endpackage

### hw/rtl/pidwd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidwd_regs: configuration register file
// APB-style write and read access to the eight controller registers.
// ----------------------------------------------------------------------------
module pidwd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidwd_pkg::ADDR_W-1:0] paddr,
  input  logic [pidwd_pkg::DATA_W-1:0] pwdata,
  output logic [pidwd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output pidwd_pkg::cfg_t             cfg,
  output logic                        run_clear
);
  import pidwd_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  // Switching the loop off discards the integral and the previous error at once.
  assign run_clear = wr_en && (idx == REG_RUN_ENABLE) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p        <= GAIN_RST;
      cfg_r.gain_i        <= GAIN_RST;
      cfg_r.gain_d        <= GAIN_RST;
      cfg_r.out_low       <= OUT_LOW_RST;
      cfg_r.out_high      <= OUT_HIGH_RST;
      cfg_r.target        <= TARGET_RST;
      cfg_r.windup_factor <= WF_RST;
      cfg_r.run_enable    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:        cfg_r.gain_p        <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:        cfg_r.gain_i        <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:        cfg_r.gain_d        <= pwdata[GAIN_W-1:0];
        REG_OUT_LOW:       cfg_r.out_low       <= pwdata[DRIVE_W-1:0];
        REG_OUT_HIGH:      cfg_r.out_high      <= pwdata[DRIVE_W-1:0];
        REG_TARGET:        cfg_r.target        <= pwdata[DRIVE_W-1:0];
        REG_WINDUP_FACTOR: cfg_r.windup_factor <= pwdata[WF_W-1:0];
        REG_RUN_ENABLE:    cfg_r.run_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:        prdata = DATA_W'(cfg_r.gain_p);
      REG_GAIN_I:        prdata = DATA_W'(cfg_r.gain_i);
      REG_GAIN_D:        prdata = DATA_W'(cfg_r.gain_d);
      REG_OUT_LOW:       prdata = DATA_W'(cfg_r.out_low);
      REG_OUT_HIGH:      prdata = DATA_W'(cfg_r.out_high);
      REG_TARGET:        prdata = DATA_W'(cfg_r.target);
      REG_WINDUP_FACTOR: prdata = DATA_W'(cfg_r.windup_factor);
      REG_RUN_ENABLE:    prdata = DATA_W'(cfg_r.run_enable);
      default:           prdata = '0;
    endcase
  end

endmodule

### hw/rtl/pidwd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidwd_ctrl: sequencing controller
// Steps one sample through the shared multiplier and owns the result valid.
// ----------------------------------------------------------------------------
module pidwd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            run_enable,
  output pidwd_pkg::cmd_t cmd
);
  import pidwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MW,
    S_MP,
    S_MD,
    S_MI,
    S_ACC,
    S_FIN,
    S_OFF
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // A waiting result may be replaced in the cycle in which it is taken.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = MUL_WF;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (run_enable) begin
            cmd.take_run = 1'b1;
            state_nxt    = S_MW;
          end else begin
            cmd.take_off = 1'b1;
            state_nxt    = S_OFF;
          end
        end
      end
      S_MW: begin
        cmd.mul_sel = MUL_WF;
        state_nxt   = S_MP;
      end
      S_MP: begin
        cmd.mul_sel  = MUL_P;
        cmd.integ_en = 1'b1;
        cmd.acc_clr  = 1'b1;
        state_nxt    = S_MD;
      end
      S_MD: begin
        cmd.mul_sel = MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = S_MI;
      end
      S_MI: begin
        cmd.mul_sel = MUL_I;
        cmd.acc_add = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit_run = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_OFF: begin
        if (slot_free) begin
          cmd.commit_off = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit_run || cmd.commit_off) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/pidwd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidwd_dp: controller datapath
// Error terms, damped integral, shared multiplier, accumulator and clamp.
// ----------------------------------------------------------------------------
module pidwd_dp #(
  parameter int SAMPLE_BITS    = pidwd_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pidwd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pidwd_pkg::cfg_t                      cfg,
  input  logic                                 run_clear,
  input  pidwd_pkg::cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0]        in_measured,
  output logic signed [pidwd_pkg::DRIVE_W-1:0] out_drive,
  output logic                                 out_running
);
  import pidwd_pkg::*;

  localparam int ERR_W = ((SAMPLE_BITS > DRIVE_W) ? SAMPLE_BITS : DRIVE_W) + 1;
  localparam int DER_W = ERR_W + 1;
  localparam int MA_W  = (DER_W > INTEG_W) ? DER_W : INTEG_W;
  localparam int MB_W  = WF_W + 1;
  localparam int PR_W  = MA_W + MB_W;
  localparam int ST_W  = PR_W - 16;
  localparam int IS_W  = ST_W + 1;
  localparam int ACC_W = PR_W + 2;
  localparam int RND_W = ACC_W + 1;

  localparam logic signed [PR_W-1:0]  WF_HALF = PR_W'(32768);
  localparam logic signed [RND_W-1:0] HALF    = (RND_W'(1) << GAIN_FRAC_BITS) >> 1;
  localparam logic signed [IS_W-1:0]  I_MAX   = $signed({{(IS_W-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [IS_W-1:0]  I_MIN   = ~I_MAX;

  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [DER_W-1:0]   deriv_r;
  logic                      sat_r;
  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [INTEG_W-1:0] integral_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [DRIVE_W-1:0] last_drive_r;
  logic signed [PR_W-1:0]    prod_r;
  logic signed [PR_W-1:0]    prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_running_r;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PR_W-1:0]    wf_round;
  logic signed [ST_W-1:0]    step_w;
  logic signed [IS_W-1:0]    inc;
  logic signed [IS_W-1:0]    isum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   val;
  logic signed [DRIVE_W-1:0] clamped;

  assign err_nxt = ERR_W'(cfg.target) - ERR_W'(in_measured);

  // The damped step is the windup product rounded to the nearest integer.
  assign wf_round = prod_r + WF_HALF;
  assign step_w   = $signed(wf_round[PR_W-1:16]);
  assign inc      = sat_r ? IS_W'(step_w) : IS_W'(err_r);
  assign isum     = IS_W'(integral_r) + inc;

  always_comb begin
    if (isum > I_MAX) begin
      integ_nxt = 32'sh7FFF_FFFF;
    end else if (isum < I_MIN) begin
      integ_nxt = 32'sh8000_0000;
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_WF: begin
        mul_a = MA_W'(err_r);
        mul_b = $signed({1'b0, cfg.windup_factor});
      end
      MUL_P: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(cfg.gain_p);
      end
      MUL_D: begin
        mul_a = MA_W'(deriv_r);
        mul_b = MB_W'(cfg.gain_d);
      end
      MUL_I: begin
        mul_a = MA_W'(integ_r);
        mul_b = MB_W'(cfg.gain_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Taking the upper bits of the rounded sum is a floor shift.
  assign rnd = RND_W'(acc_r) + HALF;
  assign val = rnd >>> GAIN_FRAC_BITS;

  // With inverted limits, a value above the high limit clamps high, else low.
  always_comb begin
    if (val > RND_W'(cfg.out_high)) begin
      clamped = cfg.out_high;
    end else if (val < RND_W'(cfg.out_low)) begin
      clamped = cfg.out_low;
    end else begin
      clamped = val[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.take_run) begin
      err_r   <= err_nxt;
      deriv_r <= DER_W'(err_nxt) - DER_W'(last_error_r);
      sat_r   <= (last_drive_r >= cfg.out_high) || (last_drive_r <= cfg.out_low);
    end
    if (cmd.integ_en) begin
      integ_r <= integ_nxt;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.commit_run) begin
      out_drive_r   <= clamped;
      out_running_r <= 1'b1;
    end else if (cmd.commit_off) begin
      out_drive_r   <= last_drive_r;
      out_running_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      last_error_r <= '0;
      last_drive_r <= '0;
    end else begin
      if (run_clear || cmd.take_off) begin
        integral_r   <= '0;
        last_error_r <= '0;
      end else if (cmd.commit_run) begin
        integral_r   <= integ_r;
        last_error_r <= err_r;
      end
      if (cmd.commit_run) begin
        last_drive_r <= clamped;
      end
    end
  end

  assign out_drive   = out_drive_r;
  assign out_running = out_running_r;

endmodule

### hw/rtl/pid_controller_windup_damped_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_windup_damped_unit: PID drive controller with damped windup
// One measured sample in, one clamped drive value out, APB configuration.
// ----------------------------------------------------------------------------
//   Channel  Ports                                   Handshake
//   in       in_measured                             in_valid / in_ready
//   out      out_drive, out_running                  out_valid / out_ready
//   cfg      psel penable pwrite paddr pwdata prdata APB, pready tied high
//
// A running sample steps through states MW, MP, MD, MI, ACC and FIN: the
// four products (windup, P, D, I) share one multiplier, one per cycle, then
// the accumulate and the round-and-clamp step. A disabled sample uses OFF.
// rst_n is synchronous; it restores the register defaults and clears state.
// A result that is not taken holds the controller in its final cycle, with the
// input side closed until the result register can be reloaded.
// ----------------------------------------------------------------------------
module pid_controller_windup_damped_unit #(
  parameter int SAMPLE_BITS    = pidwd_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pidwd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_measured,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidwd_pkg::DRIVE_W-1:0] out_drive,
  output logic                                 out_running,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidwd_pkg::ADDR_W-1:0]         paddr,
  input  logic [pidwd_pkg::DATA_W-1:0]         pwdata,
  output logic [pidwd_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import pidwd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic run_clear;

  pidwd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .run_clear (run_clear)
  );

  pidwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .run_enable (cfg.run_enable),
    .cmd        (cmd)
  );

  pidwd_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .run_clear   (run_clear),
    .cmd         (cmd),
    .in_measured (in_measured),
    .out_drive   (out_drive),
    .out_running (out_running)
  );

  // Only one sample is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while a sample was in flight");

  // A fresh result is issued as the controller returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while the controller was still busy");

  // A computed drive respects ordered limits.
  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_running && (cfg.out_low <= cfg.out_high)
    |-> (out_drive >= cfg.out_low) && (out_drive <= cfg.out_high))
    else $error("computed drive outside the configured limits");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pid_controller_windup_damped_unit
// Drives measured samples and APB register writes, predicts each drive value
// with an in-bench fixed-point PID model and checks every result in order.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [15:0] drive;
  logic               running;
} drive_expect_t;

class drive_scoreboard;
  longint        kp, ki, kd, lim_lo, lim_hi, setpoint, windup;
  bit            enabled;
  longint        integ_acc, prev_err, held_drive;
  drive_expect_t drive_expected[$];
  int            mismatches;

  function new();
    kp         = longint'(pidwd_pkg::GAIN_RST);
    ki         = longint'(pidwd_pkg::GAIN_RST);
    kd         = longint'(pidwd_pkg::GAIN_RST);
    lim_lo     = longint'(pidwd_pkg::OUT_LOW_RST);
    lim_hi     = longint'(pidwd_pkg::OUT_HIGH_RST);
    setpoint   = longint'(pidwd_pkg::TARGET_RST);
    windup     = longint'(pidwd_pkg::WF_RST);
    enabled    = 1'b0;
    integ_acc  = 0;
    prev_err   = 0;
    held_drive = 0;
    mismatches = 0;
  endfunction

  function void write_reg(pidwd_pkg::reg_idx_t idx, logic [31:0] data);
    case (idx)
      pidwd_pkg::REG_GAIN_P:        kp       = longint'($signed(data[15:0]));
      pidwd_pkg::REG_GAIN_I:        ki       = longint'($signed(data[15:0]));
      pidwd_pkg::REG_GAIN_D:        kd       = longint'($signed(data[15:0]));
      pidwd_pkg::REG_OUT_LOW:       lim_lo   = longint'($signed(data[15:0]));
      pidwd_pkg::REG_OUT_HIGH:      lim_hi   = longint'($signed(data[15:0]));
      pidwd_pkg::REG_TARGET:        setpoint = longint'($signed(data[15:0]));
      pidwd_pkg::REG_WINDUP_FACTOR: windup   = longint'(data[16:0]);
      pidwd_pkg::REG_RUN_ENABLE: begin
        enabled = data[0];
        // Switching the loop off clears the integral and the error history at once.
        if (!enabled) begin
          integ_acc = 0;
          prev_err  = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_sample(logic signed [15:0] meas);
    longint        err, deriv, step, integ, total, val, half;
    drive_expect_t e;
    if (!enabled) begin
      integ_acc = 0;
      prev_err  = 0;
      e.drive   = held_drive[15:0];
      e.running = 1'b0;
      drive_expected.push_back(e);
      return;
    end
    err   = setpoint - longint'(meas);
    deriv = err - prev_err;
    // A drive that sat on either limit last tick selects the damped integral step.
    if (held_drive >= lim_hi || held_drive <= lim_lo)
      step = (err * windup + 32768) >>> 16;
    else
      step = err;
    integ = integ_acc + step;
    if (integ > 64'sd2147483647)
      integ = 64'sd2147483647;
    if (integ < -64'sd2147483648)
      integ = -64'sd2147483648;
    integ_acc = integ;
    total = kp * err + ki * integ + kd * deriv;
    half  = (longint'(1) << pidwd_pkg::GAIN_FRAC_BITS_DEF) >>> 1;
    val   = (total + half) >>> pidwd_pkg::GAIN_FRAC_BITS_DEF;
    if (val > lim_hi)
      val = lim_hi;
    else if (val < lim_lo)
      val = lim_lo;
    held_drive = val;
    prev_err   = err;
    e.drive    = val[15:0];
    e.running  = 1'b1;
    drive_expected.push_back(e);
  endfunction

  function void check_drive(logic signed [15:0] drive, logic running);
    drive_expect_t e;
    if (drive_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result drive=%0d running=%b", $realtime, drive, running);
      return;
    end
    e = drive_expected.pop_front();
    if (drive !== e.drive || running !== e.running) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: drive mismatch: expected drive=%0d running=%b, got drive=%0d running=%b",
                 $realtime, e.drive, e.running, drive, running);
    end
  endfunction

  function int pending();
    return drive_expected.size();
  endfunction

  function int failures();
    return mismatches + drive_expected.size();
  endfunction
endclass

module testbench;
  localparam int CLK_HALF = 6;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic signed [15:0]  in_measured;
  logic                out_valid;
  logic                out_ready;
  logic signed [15:0]  out_drive;
  logic                out_running;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bit                  idle_on;
  bit                  stall_on;
  drive_scoreboard     sb;

  pid_controller_windup_damped_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .out_running (out_running),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_drive(out_drive, out_running);
      if (in_valid && in_ready)
        sb.note_sample(in_measured);
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [15:0] meas);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_measured <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Sender holds off until every outstanding drive value has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input pidwd_pkg::reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int gp, input int gi, input int gd, input int lo,
                               input int hi, input int tgt, input int wf, input bit en);
    drain_results();
    write_reg(pidwd_pkg::REG_GAIN_P, 32'(gp));
    write_reg(pidwd_pkg::REG_GAIN_I, 32'(gi));
    write_reg(pidwd_pkg::REG_GAIN_D, 32'(gd));
    write_reg(pidwd_pkg::REG_OUT_LOW, 32'(lo));
    write_reg(pidwd_pkg::REG_OUT_HIGH, 32'(hi));
    write_reg(pidwd_pkg::REG_TARGET, 32'(tgt));
    write_reg(pidwd_pkg::REG_WINDUP_FACTOR, 32'(wf));
    write_reg(pidwd_pkg::REG_RUN_ENABLE, 32'(en));
  endtask

  function automatic int rand_gain();
    if ($urandom_range(0, 3) == 0)
      return int'($signed(16'($urandom())));
    return int'($urandom_range(0, 1024)) - 512;
  endfunction

  function automatic logic [15:0] rand_measure(input int tgt);
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom());
      2: return 16'(tgt + int'($urandom_range(0, 400)) - 200);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic apply_random_setting(input bit force_run, output int tgt);
    int lo, hi, a, b, wf;
    bit en;
    case ($urandom_range(0, 7))
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: begin
        // Inverted limits: low at or above high.
        a  = int'($urandom_range(0, 8000)) - 4000;
        b  = int'($urandom_range(0, 8000)) - 4000;
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = int'($urandom_range(0, 8000)) - 4000;
        hi = lo + int'($urandom_range(0, 6000));
      end
    endcase
    case ($urandom_range(0, 5))
      0: wf = 0;
      1: wf = 65536;
      2: wf = 131071;
      3: wf = int'($urandom_range(0, 131071));
      default: wf = int'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 1) == 0)
      tgt = int'($signed(16'($urandom())));
    else
      tgt = int'($urandom_range(0, 2000)) - 1000;
    en = force_run || ($urandom_range(0, 6) != 0);
    apply_setting(rand_gain(), rand_gain(), rand_gain(), lo, hi, tgt, wf, en);
  endtask

  initial begin
    int tgt;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_measured = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b0;
    stall_on    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Straight after reset the loop is off: the held drive comes back unchanged.
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    // Unity proportional gain, full limits; the most negative sample hits the upper rail.
    apply_setting(256, 0, 0, -32768, 32767, 0, 3277, 1'b1);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);

    // Largest gains and windup factor with narrow limits.
    apply_setting(32767, 32767, -32768, -100, 100, 32767, 131071, 1'b1);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'hAAAA);

    // Inverted limits with an undamped windup factor.
    apply_setting(256, 16, 64, 50, -50, 0, 65536, 1'b1);
    send_sample(16'hFC18);
    send_sample(16'h0000);
    send_sample(16'h03E8);
    send_sample(16'hFFEC);

    // Turning the loop off and on again clears the integral and error history.
    drain_results();
    write_reg(pidwd_pkg::REG_RUN_ENABLE, 32'd0);
    send_sample(16'd123);
    drain_results();
    write_reg(pidwd_pkg::REG_RUN_ENABLE, 32'd1);
    send_sample(16'd5);

    // Most negative proportional gain and a zero windup factor.
    apply_setting(-32768, -256, 256, -32768, 32767, -32768, 0, 1'b1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    for (int ph = 0; ph < 8; ph++) begin
      apply_random_setting(ph == 7, tgt);
      idle_on  = (ph < 7);
      stall_on = (ph < 7);
      for (int i = 0; i < 100; i++) begin
        if (i == 50)
          drain_results();
        if (idle_on && $urandom_range(0, 3) == 0)
          sender_gap($urandom_range(1, 8));
        send_sample(rand_measure(tgt));
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.failures() == 0)
      $display("pid_controller_windup_damped_unit verification clean");
    else
      $display("pid_controller_windup_damped_unit verification failed");
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 400000);
    $display("pid_controller_windup_damped_unit verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pidwd_pkg.sv
hw/rtl/pidwd_regs.sv
hw/rtl/pidwd_ctrl.sv
hw/rtl/pidwd_dp.sv
hw/rtl/pid_controller_windup_damped_unit.sv
tb/sv/testbench.sv
